// File: hdl/cwef_pkg.sv
// Shared types, constants and helpers for the control write echo filter.
// No dependencies; the other files in hdl/ except cwef_ram refer to this package by scoped names.
package cwef_pkg;

	localparam int PEND_DEPTH = 32;
	localparam int PEND_AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int PEND_CW = $clog2(PEND_DEPTH + 1);

	localparam int VAL_W = 16;
	localparam int ADDR_W = 16;

	typedef enum logic [1:0] {
		OP_LEVEL_WR = 2'd0,
		OP_MUTE_WR  = 2'd1,
		OP_REPORT   = 2'd2,
		OP_ENUM     = 2'd3
	} op_t;

	// register index = paddr[3:2]
	localparam logic [1:0] REG_LEVEL_ADDR = 2'd0;
	localparam logic [1:0] REG_LEVEL_PRES = 2'd1;
	localparam logic [1:0] REG_MUTE_ADDR  = 2'd2;
	localparam logic [1:0] REG_MUTE_PRES  = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] level_address;
		logic              level_present;
		logic [ADDR_W-1:0] mute_address;
		logic              mute_present;
	} cfg_t;

	// last field in the lowest bits
	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [ADDR_W-1:0] address;
		op_t               operation;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  write_value;
		logic [ADDR_W-1:0] write_address;
		logic              issue_write;
		logic              changed;
		logic              mute;
		logic [VAL_W-1:0]  level;
	} result_t;

	localparam int IN_BITS   = $bits(item_t);
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = $bits(result_t);
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic capture;   // latch the accepted item
		logic exec;      // decode and run the work that needs no list walk
		logic search;    // one compare step of the list walk
		logic out_load;  // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic search_needed;
		logic search_done;
	} sts_t;

	// base + off modulo the list depth; base < depth, off <= depth
	function automatic logic [PEND_AW-1:0] ring_addr(input logic [PEND_AW-1:0] base,
			input logic [PEND_CW:0] off);
		logic [PEND_CW:0] sum;
		sum = (PEND_CW+1)'(base) + off;
		if (sum >= (PEND_CW+1)'(PEND_DEPTH)) begin
			sum = sum - (PEND_CW+1)'(PEND_DEPTH);
		end
		return sum[PEND_AW-1:0];
	endfunction

endpackage

// File: hdl/cwef_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cwef_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/cwef_dp.sv
// Datapath: item register, current level/mute, two ring-buffer pending lists and result.
// Depends on cwef_pkg and cwef_ram.
module cwef_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  cwef_pkg::cfg_t   cfg,
	input  cwef_pkg::item_t  in_item,
	input  cwef_pkg::cmd_t   cmd,
	output cwef_pkg::sts_t   sts,
	output cwef_pkg::result_t res
);

	cwef_pkg::item_t                  item_q;
	logic [cwef_pkg::VAL_W-1:0]       level_now_q;
	logic                             mute_now_q;
	logic [cwef_pkg::PEND_AW-1:0]     lhead_q, mhead_q;
	logic [cwef_pkg::PEND_CW-1:0]     lcnt_q, mcnt_q;
	logic [cwef_pkg::PEND_CW-1:0]     idx_q, cidx_q;
	logic                             changed_q, issue_q;
	logic [cwef_pkg::ADDR_W-1:0]      waddr_q;
	logic [cwef_pkg::VAL_W-1:0]       wval_q;

	logic                             is_level, is_mute, mute_bit, hit, last;
	logic [cwef_pkg::PEND_CW-1:0]     cur_cnt;
	logic                             lvl_we, mute_we;
	logic [cwef_pkg::PEND_AW-1:0]     lvl_waddr, mute_waddr, lvl_raddr, mute_raddr;
	logic [cwef_pkg::VAL_W-1:0]       lvl_rdata;
	logic                             mute_rdata;
	logic [cwef_pkg::PEND_CW:0]       retire_off;
	logic                             lvl_diff, mute_diff, lvl_full, mute_full;

	assign is_level = cfg.level_present && (item_q.address == cfg.level_address);
	assign is_mute = !is_level && cfg.mute_present && (item_q.address == cfg.mute_address);
	assign mute_bit = |item_q.value;
	assign cur_cnt = is_mute ? mcnt_q : lcnt_q;
	assign lvl_diff = item_q.value != level_now_q;
	assign mute_diff = mute_bit != mute_now_q;
	assign lvl_full = lcnt_q == cwef_pkg::PEND_CW'(cwef_pkg::PEND_DEPTH);
	assign mute_full = mcnt_q == cwef_pkg::PEND_CW'(cwef_pkg::PEND_DEPTH);

	assign sts.search_needed = (item_q.operation == cwef_pkg::OP_REPORT) &&
		(is_level || is_mute) && (cur_cnt != '0);

	// rdata/cidx_q belong to the read issued in the previous cycle
	assign hit = is_mute ? (mute_rdata == mute_bit) : (lvl_rdata == item_q.value);
	assign last = ({1'b0, cidx_q} + (cwef_pkg::PEND_CW+1)'(1)) == {1'b0, cur_cnt};
	assign sts.search_done = hit || last;
	assign retire_off = {1'b0, cidx_q} + (cwef_pkg::PEND_CW+1)'(1);

	assign lvl_we = cmd.exec && (item_q.operation == cwef_pkg::OP_LEVEL_WR) &&
		cfg.level_present && lvl_diff;
	assign mute_we = cmd.exec && (item_q.operation == cwef_pkg::OP_MUTE_WR) &&
		cfg.mute_present;
	assign lvl_waddr = cwef_pkg::ring_addr(lhead_q, {1'b0, lcnt_q});
	assign mute_waddr = cwef_pkg::ring_addr(mhead_q, {1'b0, mcnt_q});
	assign lvl_raddr = cwef_pkg::ring_addr(lhead_q, {1'b0, idx_q});
	assign mute_raddr = cwef_pkg::ring_addr(mhead_q, {1'b0, idx_q});

	cwef_ram #(.DEPTH(cwef_pkg::PEND_DEPTH), .WIDTH(cwef_pkg::VAL_W)) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (item_q.value),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	cwef_ram #(.DEPTH(cwef_pkg::PEND_DEPTH), .WIDTH(1)) u_mute_ram (
		.clk   (clk),
		.we    (mute_we),
		.waddr (mute_waddr),
		.wdata (mute_bit),
		.raddr (mute_raddr),
		.rdata (mute_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		cidx_q <= idx_q;
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (cmd.exec) begin
			changed_q <= 1'b0;
			issue_q <= 1'b0;
			waddr_q <= '0;
			wval_q <= '0;
			unique case (item_q.operation)
				cwef_pkg::OP_LEVEL_WR: begin
					if (lvl_we) begin
						changed_q <= 1'b1;
						issue_q <= 1'b1;
						waddr_q <= cfg.level_address;
						wval_q <= item_q.value;
					end
				end
				cwef_pkg::OP_MUTE_WR: begin
					if (cfg.mute_present) begin
						changed_q <= 1'b1;
						issue_q <= 1'b1;
						waddr_q <= cfg.mute_address;
						wval_q <= cwef_pkg::VAL_W'(mute_bit);
					end
				end
				cwef_pkg::OP_REPORT: begin
					// empty list: straight miss
					if ((is_level || is_mute) && cur_cnt == '0) begin
						changed_q <= is_mute ? mute_diff : lvl_diff;
					end
				end
				default: ;
			endcase
		end
		if (cmd.search && !hit && last) begin
			changed_q <= is_mute ? mute_diff : lvl_diff;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_now_q <= '0;
			mute_now_q <= 1'b0;
			lhead_q <= '0;
			mhead_q <= '0;
			lcnt_q <= '0;
			mcnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.exec) begin
				unique case (item_q.operation)
					cwef_pkg::OP_LEVEL_WR: begin
						if (lvl_we) begin
							level_now_q <= item_q.value;
							if (lvl_full) begin
								lhead_q <= cwef_pkg::ring_addr(lhead_q,
									(cwef_pkg::PEND_CW+1)'(1));
							end else begin
								lcnt_q <= lcnt_q + cwef_pkg::PEND_CW'(1);
							end
						end
					end
					cwef_pkg::OP_MUTE_WR: begin
						if (cfg.mute_present) begin
							mute_now_q <= mute_bit;
							if (mute_full) begin
								mhead_q <= cwef_pkg::ring_addr(mhead_q,
									(cwef_pkg::PEND_CW+1)'(1));
							end else begin
								mcnt_q <= mcnt_q + cwef_pkg::PEND_CW'(1);
							end
						end
					end
					cwef_pkg::OP_REPORT: begin
						if (is_mute && mcnt_q == '0) begin
							mute_now_q <= mute_bit;
						end else if (is_level && lcnt_q == '0) begin
							level_now_q <= item_q.value;
						end
						if (sts.search_needed) begin
							idx_q <= cwef_pkg::PEND_CW'(1);
						end
					end
					cwef_pkg::OP_ENUM: begin
						if (is_level) begin
							level_now_q <= item_q.value;
						end else if (is_mute) begin
							mute_now_q <= mute_bit;
						end
					end
					default: ;
				endcase
			end
			if (cmd.search) begin
				if (hit) begin
					// echo: drop the match and everything older
					idx_q <= '0;
					if (is_mute) begin
						mhead_q <= cwef_pkg::ring_addr(mhead_q, retire_off);
						mcnt_q <= mcnt_q - retire_off[cwef_pkg::PEND_CW-1:0];
					end else begin
						lhead_q <= cwef_pkg::ring_addr(lhead_q, retire_off);
						lcnt_q <= lcnt_q - retire_off[cwef_pkg::PEND_CW-1:0];
					end
				end else if (last) begin
					idx_q <= '0;
					if (is_mute) begin
						mcnt_q <= '0;
						mute_now_q <= mute_bit;
					end else begin
						lcnt_q <= '0;
						level_now_q <= item_q.value;
					end
				end else begin
					idx_q <= idx_q + cwef_pkg::PEND_CW'(1);
				end
			end
		end
	end

	assign res.level = level_now_q;
	assign res.mute = mute_now_q;
	assign res.changed = changed_q;
	assign res.issue_write = issue_q;
	assign res.write_address = waddr_q;
	assign res.write_value = wval_q;

`ifndef SYNTH
	a_lcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= cwef_pkg::PEND_CW'(cwef_pkg::PEND_DEPTH) &&
		mcnt_q <= cwef_pkg::PEND_CW'(cwef_pkg::PEND_DEPTH))
		else $error("pending count above depth");
	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> cidx_q < cur_cnt)
		else $error("list walk beyond count");
	a_hit_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search && hit && !is_mute |=> lcnt_q < $past(lcnt_q))
		else $error("echo did not retire level entries");
`endif

endmodule

// File: hdl/cwef_ctrl.sv
// Controller state machine: sequences capture, decode, list walk and result hand-off.
// Depends on cwef_pkg.
module cwef_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           out_free,
	input  cwef_pkg::sts_t sts,
	output cwef_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_FIN    = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = sts.search_needed ? ST_SEARCH : ST_FIN;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.search_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !out_free |=> state_q == ST_FIN)
		else $error("result dropped under stall");
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_SEARCH || state_q == ST_FIN)
		else $error("decode step not followed by walk or finish");
	a_search_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH && sts.search_done |=> state_q == ST_FIN)
		else $error("list walk did not finish");
`endif

endmodule

// File: hdl/control_write_echo_filter_unit.sv
// Top level of the control write echo filter: APB register file, output register,
// and the controller/datapath pair. Depends on cwef_pkg, cwef_ctrl, cwef_dp.
//
// Usage:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one item per transfer:
//    local level write, local mute write, server report or enumeration value.
//  - Output stream (m_tvalid/m_tready/m_tdata) returns exactly one result per item:
//    current level and mute, change flag, and the server write to issue (if any).
//  - APB port holds level/mute addresses and present bits; write it only while idle.
// Sequence:
//  - Writes, enumeration items and reports that need no walk: capture (ST_IDLE), decode
//    and execute (ST_EXEC), then load into the output register (ST_FIN), which raises m_tvalid.
//  - Other server reports walk the pending list one entry per cycle through the list RAM's
//    registered read port (ST_SEARCH) between decode and output load, comparing up to
//    32 entries. A new item is taken only once the previous one is in the output
//    register.
// Reset (arst_n low): level and mute clear to 0, both pending lists empty, registers
//   zero, output register empty. No clearing pass is needed.
// Stall: the output register holds its result while m_tready is low; one further item
//   may be accepted and worked on, then it waits until the register frees.
module control_write_echo_filter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cwef_pkg::IN_TDATA-1:0]  s_tdata,  // operation[1:0], address[17:2], value[33:18]
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cwef_pkg::OUT_TDATA-1:0] m_tdata   // level[15:0], mute[16], changed[17],
	                                                 // issue_write[18], write_address[34:19],
	                                                 // write_value[50:35]
);

	cwef_pkg::cfg_t    cfg_q;
	cwef_pkg::cmd_t    cmd;
	cwef_pkg::sts_t    sts;
	cwef_pkg::result_t res;
	cwef_pkg::item_t   in_item;
	cwef_pkg::result_t out_q;
	logic              out_valid_q;
	logic              out_free;
	logic              cfg_wr;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				cwef_pkg::REG_LEVEL_ADDR: cfg_q.level_address <= pwdata[cwef_pkg::ADDR_W-1:0];
				cwef_pkg::REG_LEVEL_PRES: cfg_q.level_present <= pwdata[0];
				cwef_pkg::REG_MUTE_ADDR:  cfg_q.mute_address <= pwdata[cwef_pkg::ADDR_W-1:0];
				cwef_pkg::REG_MUTE_PRES:  cfg_q.mute_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cwef_pkg::REG_LEVEL_ADDR: prdata = 32'(cfg_q.level_address);
			cwef_pkg::REG_LEVEL_PRES: prdata = 32'(cfg_q.level_present);
			cwef_pkg::REG_MUTE_ADDR:  prdata = 32'(cfg_q.mute_address);
			cwef_pkg::REG_MUTE_PRES:  prdata = 32'(cfg_q.mute_present);
			default:                  prdata = '0;
		endcase
	end

	// ---- input unpack ----
	assign in_item = cwef_pkg::item_t'(s_tdata[cwef_pkg::IN_BITS-1:0]);

	// ---- control and datapath ----
	cwef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	cwef_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_item (in_item),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	// ---- output register: separates the result from the next item's work ----
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = cwef_pkg::OUT_TDATA'(out_q);

endmodule

// File: test/control_write_echo_filter_unit_tb.sv
// Self-checking bench for control_write_echo_filter_unit: item stream in, status stream out.
// Depends on cwef_pkg for item, result and opcode types; the checker holds its own copy of
// the level/mute state and the in-flight write lists.
module control_write_echo_filter_unit_tb;
	import cwef_pkg::*;

	localparam int STALL_LIMIT = 4000;  // cycles with no transfer before the run is abandoned
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int TAIL_CYCLES = 40;    // covers the slowest report walk

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA-1:0] s_tdata = '0;   // operation[1:0], address[17:2], value[33:18]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA-1:0] m_tdata;       // level[15:0], mute[16], changed[17], issue_write[18],
	                                     // write_address[34:19], write_value[50:35]

	// register copies, written alongside each APB write
	logic [15:0] cfg_level_addr = '0;
	logic cfg_level_pres = 1'b0;
	logic [15:0] cfg_mute_addr = '0;
	logic cfg_mute_pres = 1'b0;

	// tracked control state
	logic [15:0] level_now = '0;
	logic mute_now = 1'b0;
	logic [15:0] level_inflight[$];
	logic [15:0] mute_inflight[$];   // single bits, zero-extended

	logic [IN_TDATA-1:0] control_items[$];   // packed items waiting for the driver
	result_t status_due[$];                  // expected status per accepted item
	int items_made = 0;
	int errors = 0;

	// stimulus knobs, set by the sequence at falling edges
	int idle_odds = 0;          // percent chance per cycle of starting an idle burst
	logic long_hold_req = 1'b0;

	int send_gap = 0;
	int recv_gap = 0;
	int hold_cnt = 0;
	logic hold_done = 1'b0;
	int quiet_cycles = 0;

	control_write_echo_filter_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// append a local write; the oldest entry falls out when the list is full
	function automatic void inflight_push(ref logic [15:0] lst[$], input logic [15:0] v);
		if (lst.size() >= PEND_DEPTH) begin
			void'(lst.pop_front());
		end
		lst.push_back(v);
	endfunction

	// echo: retire the match and everything older; otherwise the list is stale, so clear it
	function automatic bit inflight_echo(ref logic [15:0] lst[$], input logic [15:0] v);
		int k;
		for (k = 0; k < lst.size(); k++) begin
			if (lst[k] == v) begin
				repeat (k + 1) void'(lst.pop_front());
				return 1'b1;
			end
		end
		lst.delete();
		return 1'b0;
	endfunction

	function automatic result_t apply_item(input item_t it);
		result_t r;
		logic hit_level, hit_mute, m;
		r = '0;
		// shared address: the level control wins
		hit_level = cfg_level_pres && it.address == cfg_level_addr;
		hit_mute = !hit_level && cfg_mute_pres && it.address == cfg_mute_addr;
		m = it.value != 16'd0;
		case (it.operation)
		OP_LEVEL_WR: begin
			// skipped when absent or when the level does not move
			if (cfg_level_pres && it.value != level_now) begin
				level_now = it.value;
				inflight_push(level_inflight, it.value);
				r.issue_write = 1'b1;
				r.write_address = cfg_level_addr;
				r.write_value = it.value;
				r.changed = 1'b1;
			end
		end
		OP_MUTE_WR: begin
			// sent and flagged whenever present, even when mute does not move
			if (cfg_mute_pres) begin
				mute_now = m;
				inflight_push(mute_inflight, {15'd0, m});
				r.issue_write = 1'b1;
				r.write_address = cfg_mute_addr;
				r.write_value = {15'd0, m};
				r.changed = 1'b1;
			end
		end
		OP_REPORT: begin
			if (hit_level) begin
				if (!inflight_echo(level_inflight, it.value) && it.value != level_now) begin
					level_now = it.value;
					r.changed = 1'b1;
				end
			end else if (hit_mute) begin
				if (!inflight_echo(mute_inflight, {15'd0, m}) && m != mute_now) begin
					mute_now = m;
					r.changed = 1'b1;
				end
			end
		end
		default: begin
			// enumeration: silent set, lists untouched
			if (hit_level) begin
				level_now = it.value;
			end else if (hit_mute) begin
				mute_now = m;
			end
		end
		endcase
		r.level = level_now;
		r.mute = mute_now;
		return r;
	endfunction

	task automatic check_status(input result_t got);
		result_t want;
		if (status_due.size() == 0) begin
			$error("status transfer with nothing expected: %h", got);
			errors++;
			return;
		end
		want = status_due.pop_front();
		if (got.level !== want.level) begin
			$error("level: expected %h, got %h", want.level, got.level);
			errors++;
		end
		if (got.mute !== want.mute) begin
			$error("mute: expected %b, got %b", want.mute, got.mute);
			errors++;
		end
		if (got.changed !== want.changed) begin
			$error("changed: expected %b, got %b", want.changed, got.changed);
			errors++;
		end
		if (got.issue_write !== want.issue_write) begin
			$error("issue_write: expected %b, got %b", want.issue_write, got.issue_write);
			errors++;
		end
		if (got.write_address !== want.write_address) begin
			$error("write_address: expected %h, got %h", want.write_address,
				got.write_address);
			errors++;
		end
		if (got.write_value !== want.write_value) begin
			$error("write_value: expected %h, got %h", want.write_value, got.write_value);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------- driver
	// Prediction runs at the accepting edge, so the expected queue always
	// reflects exactly the items the block has taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				status_due.push_back(apply_item(item_t'(s_tdata[IN_BITS-1:0])));
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered item until it is taken
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (control_items.size() != 0) begin
				if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
					send_gap <= $urandom_range(0, 7);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= control_items.pop_front();
					s_tvalid <= 1'b1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_status(result_t'(m_tdata[OUT_BITS-1:0]));
			end
			if (long_hold_req && !hold_done) begin
				// long back-pressure: the sender keeps offering and the block backs up
				hold_done <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
				recv_gap <= $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("control_write_echo_filter_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence helpers

	task automatic queue_item(input op_t op, input logic [15:0] addr, input logic [15:0] val);
		item_t it;
		logic [IN_TDATA-1:0] word;
		it.operation = op;
		it.address = addr;
		it.value = val;
		word = '0;
		word[IN_BITS-1:0] = it;
		control_items.push_back(word);
		items_made++;
	endtask

	// wait until every offered item is taken and every status has come back
	task automatic wait_idle();
		while (control_items.size() != 0 || s_tvalid || status_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);   // access edge: register takes the value here
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_LEVEL_ADDR: cfg_level_addr = val;
		REG_LEVEL_PRES: cfg_level_pres = val[0];
		REG_MUTE_ADDR:  cfg_mute_addr = val;
		default:        cfg_mute_pres = val[0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_controls(input logic [15:0] la, input logic lp, input logic [15:0] ma,
			input logic mp);
		wait_idle();
		write_reg(REG_LEVEL_ADDR, la);
		write_reg(REG_LEVEL_PRES, {15'd0, lp});
		write_reg(REG_MUTE_ADDR, ma);
		write_reg(REG_MUTE_PRES, {15'd0, mp});
	endtask

	// small values make equal-level skips and echo hits common
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
		0, 1:    return 16'($urandom_range(0, 3));
		2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_address();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return cfg_level_addr;
		4, 5, 6:    return cfg_mute_addr;
		7:          return cfg_level_addr ^ (16'd1 << $urandom_range(0, 15));
		8:          return cfg_mute_addr ^ (16'd1 << $urandom_range(0, 15));
		default:    return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly well-formed traffic: local writes followed by their server echoes,
	// with list overflows, enumeration values and plain noise mixed in.
	task automatic queue_random_phase(input int target);
		int first, n, k;
		logic ctl_mute;
		logic [15:0] v;
		logic [15:0] vals[$];
		first = items_made;
		while (items_made - first < target) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				ctl_mute = $urandom_range(0, 1);
				n = $urandom_range(1, 6);
				vals.delete();
				for (k = 0; k < n; k++) begin
					vals.push_back(pick_value());
					queue_item(ctl_mute ? OP_MUTE_WR : OP_LEVEL_WR,
						16'($urandom_range(0, 65535)), vals[k]);
				end
				// echoes in order, some lost on the way
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 3) != 0) begin
						v = vals[k];
						if (ctl_mute && v != 16'd0) begin
							v = 16'($urandom_range(1, 65535));
						end
						queue_item(OP_REPORT, ctl_mute ? cfg_mute_addr : cfg_level_addr, v);
					end
				end
				if ($urandom_range(0, 2) == 0) begin
					queue_item(OP_REPORT, pick_address(), pick_value());
				end
			end
			5: begin
				// run up to and past the list depth, then echo the first and the last write
				ctl_mute = $urandom_range(0, 1);
				n = $urandom_range(PEND_DEPTH - 1, PEND_DEPTH + 4);
				vals.delete();
				for (k = 0; k < n; k++) begin
					vals.push_back(16'($urandom_range(0, 65535)));
					queue_item(ctl_mute ? OP_MUTE_WR : OP_LEVEL_WR, pick_address(), vals[k]);
				end
				queue_item(OP_REPORT, ctl_mute ? cfg_mute_addr : cfg_level_addr, vals[0]);
				queue_item(OP_REPORT, ctl_mute ? cfg_mute_addr : cfg_level_addr, vals[n - 1]);
			end
			6: queue_item(OP_ENUM, pick_address(), pick_value());
			default: queue_item(op_t'($urandom_range(0, 3)), pick_address(), pick_value());
			endcase
		end
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		logic [15:0] ra, rb;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: both controls present at distinct addresses
		idle_odds = 10;
		set_controls(16'h1234, 1'b1, 16'hABCD, 1'b1);
		queue_item(OP_LEVEL_WR, 16'h0000, 16'hFFFF);
		queue_item(OP_LEVEL_WR, 16'hFFFF, 16'hFFFF);   // equal to level: skipped
		queue_item(OP_LEVEL_WR, 16'h0000, 16'h0000);
		queue_item(OP_REPORT, 16'h1234, 16'hFFFF);      // echo of the older write
		queue_item(OP_REPORT, 16'h1234, 16'h0000);      // echo of the newer write
		queue_item(OP_REPORT, 16'h1234, 16'h5555);      // foreign value: adopted
		queue_item(OP_REPORT, 16'h1234, 16'h5555);      // same value again: no change
		queue_item(OP_MUTE_WR, 16'h0000, 16'h8000);     // nonzero means muted
		queue_item(OP_MUTE_WR, 16'h0000, 16'h8000);     // repeated mute write still sent
		queue_item(OP_REPORT, 16'hABCD, 16'h0007);      // echo of a mute write
		queue_item(OP_REPORT, 16'hABCD, 16'h0000);      // no match: list cleared, unmuted
		queue_item(OP_ENUM, 16'h1234, 16'hFFFF);
		queue_item(OP_ENUM, 16'hABCD, 16'h0001);
		queue_item(OP_REPORT, 16'h0000, 16'h0001);      // unmatched address
		queue_item(OP_ENUM, 16'h1235, 16'h0002);        // unmatched address
		queue_item(OP_LEVEL_WR, 16'h5A5A, 16'h00FF);

		// directed: shared address at the top of the range, level takes it
		set_controls(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
		queue_item(OP_REPORT, 16'hFFFF, 16'h0001);
		queue_item(OP_ENUM, 16'hFFFF, 16'h0000);
		queue_item(OP_MUTE_WR, 16'h0000, 16'h0000);

		// directed: neither control present, addresses at zero
		set_controls(16'h0000, 1'b0, 16'h0000, 1'b0);
		queue_item(OP_LEVEL_WR, 16'h0000, 16'h1111);
		queue_item(OP_MUTE_WR, 16'h0000, 16'h0001);
		queue_item(OP_REPORT, 16'h0000, 16'h2222);
		queue_item(OP_ENUM, 16'h0000, 16'h3333);

		// random phases; each config change waits for the block to drain
		idle_odds = 15;
		set_controls(16'h0000, 1'b1, 16'hFFFF, 1'b1);
		queue_random_phase(100);
		long_hold_req = 1'b1;

		idle_odds = 10;
		set_controls(16'hFFFF, 1'b1, 16'h0000, 1'b1);
		queue_random_phase(100);

		ra = 16'($urandom_range(0, 65535));
		idle_odds = 20;
		set_controls(ra, 1'b1, ra, 1'b1);
		queue_random_phase(100);

		ra = 16'($urandom_range(0, 65535));
		rb = 16'($urandom_range(0, 65535));
		idle_odds = 15;
		set_controls(ra, 1'b1, rb, 1'b0);
		queue_random_phase(100);

		ra = 16'($urandom_range(0, 65535));
		rb = 16'($urandom_range(0, 65535));
		idle_odds = 10;
		set_controls(ra, 1'b0, rb, 1'b1);
		queue_random_phase(100);

		ra = 16'($urandom_range(0, 65535));
		rb = ra ^ 16'h0001;
		idle_odds = 25;
		set_controls(ra, 1'b1, rb, 1'b1);
		queue_random_phase(100);

		ra = 16'($urandom_range(0, 65535));
		rb = 16'($urandom_range(0, 65535));
		idle_odds = 0;
		set_controls(ra, 1'b1, rb, 1'b1);
		queue_random_phase(100);

		// closing stretch runs at full rate on both sides
		ra = 16'($urandom_range(0, 65535));
		rb = 16'($urandom_range(0, 65535));
		set_controls(ra, 1'b1, rb, 1'b1);
		queue_random_phase(100);

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("control_write_echo_filter_unit verification clean");
		end else begin
			$display("control_write_echo_filter_unit verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/cwef_pkg.sv
hdl/cwef_ram.sv
hdl/cwef_dp.sv
hdl/cwef_ctrl.sv
hdl/control_write_echo_filter_unit.sv
test/control_write_echo_filter_unit_tb.sv
